@@ rtl/core/tct_pkg.sv @@
`timescale 1ns / 1ps

package tct_pkg;

  localparam int LINK_COUNT = 4;
  localparam int RING_DEPTH = 8;

  localparam int MODE_W   = 2;
  localparam int LINK_IN_W = 2;
  localparam int TAG_W    = 8;
  localparam int CNT_W    = 16;
  localparam int STATUS_W = 2;

  localparam int LINK_W    = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
  localparam int SLOT_W    = $clog2(RING_DEPTH);
  localparam int FILL_W    = $clog2(RING_DEPTH + 1);
  localparam int SUM_W     = FILL_W + 1;
  localparam int ADDR_W    = LINK_W + SLOT_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam logic [MODE_W-1:0] MODE_RESERVE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [LINK_IN_W-1:0] link;
    logic [TAG_W-1:0]     owner_tag;
    logic                 owner_present;
    logic [CNT_W-1:0]     packet_count;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0] owner;
    logic             present;
    logic [CNT_W-1:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                retired;
    logic [TAG_W-1:0]    owner;
    logic                present;
    logic                last;
  } result_t;

  typedef struct packed {
    logic             a_ge_b;
    logic [CNT_W-1:0] a_minus_b;
    logic [CNT_W-1:0] b_minus_a;
  } sub_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD,
    ST_EVAL,
    ST_EMIT,
    ST_FLUSH
  } state_t;

endpackage

@@ rtl/core/tct_ram.sv @@
`timescale 1ns / 1ps

module tct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tct_sub.sv @@
`timescale 1ns / 1ps

module tct_sub (
  input  logic [tct_pkg::CNT_W-1:0] a,
  input  logic [tct_pkg::CNT_W-1:0] b,
  output tct_pkg::sub_res_t         res
);
  import tct_pkg::*;

  logic [CNT_W:0] diff;

  assign diff          = {1'b0, a} - {1'b0, b};
  assign res.a_ge_b    = ~diff[CNT_W];
  assign res.a_minus_b = diff[CNT_W-1:0];
  assign res.b_minus_a = b - a;

endmodule

@@ rtl/core/tct_seq.sv @@
`timescale 1ns / 1ps

module tct_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  tct_pkg::req_t    req,
  input  logic             out_free,
  output logic             push,
  output tct_pkg::result_t push_res
);
  import tct_pkg::*;

  state_t state, state_next;
  state_t ret_state;

  logic [MODE_W-1:0]    mode_q;
  logic [LINK_IN_W-1:0] link_q;
  logic [TAG_W-1:0]     tag_q;
  logic                 present_q;
  logic [CNT_W-1:0]     count_q;

  logic [SLOT_W-1:0] head [LINK_COUNT];
  logic [FILL_W-1:0] fill [LINK_COUNT];

  result_t res;
  result_t pend;
  logic    pend_valid;
  result_t retire_res;

  logic [LINK_W-1:0]   idx;
  logic                link_ok;
  logic [SLOT_W-1:0]   cur_head;
  logic [FILL_W-1:0]   cur_fill;
  logic [SLOT_W-1:0]   head_inc;
  logic [SUM_W-1:0]    tail_sum;
  logic [SLOT_W-1:0]   tail;
  logic                rsv_ok;
  logic                rel_ok;
  logic                cmp_go;
  logic [FILL_W-1:0]   fill_after;
  logic                last_now;
  logic [STATUS_W-1:0] disp_status;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  sub_res_t sub;

  function automatic result_t set_last(input result_t r, input logic l);
    result_t o;
    o      = r;
    o.last = l;
    return o;
  endfunction

  tct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  tct_sub u_sub (
    .a  (count_q),
    .b  (ram_rdata.remaining),
    .res(sub)
  );

  assign idx      = LINK_W'(link_q);
  assign link_ok  = 32'(link_q) < LINK_COUNT;
  assign cur_head = head[idx];
  assign cur_fill = fill[idx];
  assign head_inc = (32'(cur_head) == RING_DEPTH - 1) ? '0 : cur_head + 1'b1;
  assign tail_sum = SUM_W'(cur_head) + SUM_W'(cur_fill);
  assign tail     = (32'(tail_sum) >= RING_DEPTH) ?
                    SLOT_W'(tail_sum - SUM_W'(RING_DEPTH)) : SLOT_W'(tail_sum);

  assign rsv_ok = link_ok && (count_q != '0) && (32'(cur_fill) < RING_DEPTH);
  assign rel_ok = link_ok && (cur_fill != '0);
  assign cmp_go = (mode_q == MODE_COMPLETE) && link_ok && (count_q != '0) &&
                  (cur_fill != '0);

  assign fill_after = cur_fill - 1'b1;
  assign last_now   = (sub.a_minus_b == '0) || (fill_after == '0);

  always_comb begin
    disp_status = STATUS_OK;
    case (mode_q)
      MODE_RESERVE: begin
        if (!rsv_ok) begin
          disp_status = STATUS_REFUSED;
        end
      end
      MODE_RELEASE: begin
        if (!rel_ok) begin
          disp_status = STATUS_EMPTY;
        end
      end
      default: begin
        disp_status = STATUS_OK;
      end
    endcase
  end

  always_comb begin
    retire_res.status  = STATUS_OK;
    retire_res.retired = 1'b1;
    retire_res.owner   = ram_rdata.present ? ram_rdata.owner : '0;
    retire_res.present = ram_rdata.present;
    retire_res.last    = 1'b0;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = cmp_go ? ST_RD : ST_EMIT;
      end
      ST_RD: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sub.a_ge_b || pend_valid) begin
          state_next = ST_EMIT;
        end else begin
          state_next = last_now ? ST_FLUSH : ST_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ret_state;
        end
      end
      ST_FLUSH: begin
        state_next = ST_EMIT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE);
    push      = (state == ST_EMIT) && out_free;
    push_res  = res;
    ram_raddr = {idx, cur_head};
    ram_we    = 1'b0;
    ram_waddr = {idx, cur_head};
    ram_wdata = ram_rdata;
    case (state)
      ST_DISPATCH: begin
        ram_we    = (mode_q == MODE_RESERVE) && rsv_ok;
        ram_waddr = {idx, tail};
        ram_wdata = '{owner: tag_q, present: present_q, remaining: count_q};
      end
      ST_EVAL: begin
        ram_we              = !sub.a_ge_b;
        ram_wdata.remaining = sub.b_minus_a;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret_state  <= ST_IDLE;
      pend_valid <= 1'b0;
      for (int i = 0; i < LINK_COUNT; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            mode_q    <= req.mode;
            link_q    <= req.link;
            tag_q     <= req.owner_tag;
            present_q <= req.owner_present;
            count_q   <= req.packet_count;
          end
        end
        ST_DISPATCH: begin
          pend_valid <= 1'b0;
          ret_state  <= ST_IDLE;
          res        <= '{status: disp_status, retired: 1'b0, owner: '0, present: 1'b0,
                          last: 1'b1};
          if (mode_q == MODE_RESERVE) begin
            if (rsv_ok) begin
              fill[idx] <= cur_fill + 1'b1;
            end
          end else if (mode_q == MODE_RELEASE) begin
            if (rel_ok) begin
              fill[idx] <= fill_after;
            end
          end
        end
        ST_EVAL: begin
          if (sub.a_ge_b) begin
            count_q    <= sub.a_minus_b;
            head[idx]  <= head_inc;
            fill[idx]  <= fill_after;
            pend       <= retire_res;
            pend_valid <= 1'b1;
            if (pend_valid) begin
              res       <= set_last(pend, 1'b0);
              ret_state <= last_now ? ST_FLUSH : ST_RD;
            end
          end else begin
            ret_state <= ST_IDLE;
            if (pend_valid) begin
              res <= set_last(pend, 1'b1);
            end else begin
              res <= '{status: STATUS_OK, retired: 1'b0, owner: '0, present: 1'b0,
                       last: 1'b1};
            end
          end
        end
        ST_FLUSH: begin
          res       <= set_last(pend, 1'b1);
          ret_state <= ST_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_DISPATCH))
    else $error("accepted request did not move to dispatch");

  a_eval_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (cur_fill != '0))
    else $error("completion evaluated an empty ring");

  a_reserve_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DISPATCH && ram_we) |-> (count_q != '0 && link_ok))
    else $error("reserve wrote an entry with zero count");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into an occupied output stage");

  a_flush_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> pend_valid)
    else $error("flush without a pending retired entry");

endmodule

@@ rtl/core/tx_completion_tracker_top.sv @@
`timescale 1ns / 1ps

// Transmit completion tracker with one ring of outstanding transmissions per link.
// Requests enter on the s_axis channel: tuser carries the mode (reserve, release,
// completion) and tdata the link, owner tag, owner-present bit and packet count.
// Results leave on the m_axis channel, one or more per request; tlast marks the
// final result of a request. A completion gives one result per retired entry, or one if it retires none.
// A request is taken only while the sequencer is idle. Reserve, release, ignored
// requests and completions that find nothing to spend pass a dispatch state, which
// forms their result, and an emit state, which pushes it into the output register.
// A completion reads the ring entries one at a time through the single entry
// memory and the shared subtract unit, using a read and an evaluate state per entry.
// Each retired entry's result is held until the next step shows whether it is the
// last; a partly spent entry is written back with its remainder and ends the walk.
// Reset empties every ring at once; the entry memory needs no clearing pass.
// If the receiver stalls, the result waits in the output register and the
// sequencer holds until that register frees, so no result is lost.
module tx_completion_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // link[1:0], owner_tag[9:2], owner_present[10], packet_count[26:11], zero pad
  input  logic [31:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // done_owner[7:0], done_owner_present[8], zero pad
  output logic [15:0] m_axis_tdata,
  // status[1:0], retired[2]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import tct_pkg::*;

  req_t    req;
  logic    out_free;
  logic    push;
  result_t push_res;
  result_t out_q;
  logic    out_valid;

  assign req.mode          = s_axis_tuser;
  assign req.link          = s_axis_tdata[1:0];
  assign req.owner_tag     = s_axis_tdata[9:2];
  assign req.owner_present = s_axis_tdata[10];
  assign req.packet_count  = s_axis_tdata[26:11];

  assign out_free = !out_valid || m_axis_tready;

  tct_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_axis_tvalid),
    .req_ready(s_axis_tready),
    .req      (req),
    .out_free (out_free),
    .push     (push),
    .push_res (push_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
      out_q     <= push_res;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_q.present, out_q.owner};
  assign m_axis_tuser  = {out_q.retired, out_q.status};
  assign m_axis_tlast  = out_q.last;

endmodule

@@ tb/sv/tx_completion_checker.sv @@
`timescale 1ns / 1ps

module tx_completion_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          outstanding
);
  import tct_pkg::*;

  logic [TAG_W-1:0] slot_owner   [LINK_COUNT][RING_DEPTH];
  logic             slot_present [LINK_COUNT][RING_DEPTH];
  logic [CNT_W-1:0] slot_left    [LINK_COUNT][RING_DEPTH];
  int unsigned      ring_start   [LINK_COUNT];
  int unsigned      ring_used    [LINK_COUNT];
  result_t          due_results[$];
  int               bad_count;
  int               seen_count;

  task automatic track_request(input req_t rq);
    result_t     res;
    int unsigned lk;
    int unsigned slot;
    int unsigned n;
    int unsigned take;
    int          k;
    res = '0;
    res.status = STATUS_OK;
    res.last = 1'b1;
    lk = rq.link;
    case (rq.mode)
      MODE_RESERVE: begin
        if (lk >= LINK_COUNT || rq.packet_count == '0 || ring_used[lk] >= RING_DEPTH) begin
          res.status = STATUS_REFUSED;
        end else begin
          slot = (ring_start[lk] + ring_used[lk]) % RING_DEPTH;
          slot_owner[lk][slot] = rq.owner_tag;
          slot_present[lk][slot] = rq.owner_present;
          slot_left[lk][slot] = rq.packet_count;
          ring_used[lk]++;
        end
        due_results.push_back(res);
      end
      MODE_RELEASE: begin
        if (lk >= LINK_COUNT || ring_used[lk] == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          ring_used[lk]--;
        end
        due_results.push_back(res);
      end
      MODE_COMPLETE: begin
        k = 0;
        n = rq.packet_count;
        if (lk < LINK_COUNT) begin
          while (n > 0 && ring_used[lk] > 0 && k < RING_DEPTH) begin
            slot = ring_start[lk];
            take = (n < slot_left[lk][slot]) ? n : slot_left[lk][slot];
            slot_left[lk][slot] = slot_left[lk][slot] - CNT_W'(take);
            n = n - take;
            if (slot_left[lk][slot] != '0) break;
            ring_start[lk] = (ring_start[lk] + 1) % RING_DEPTH;
            ring_used[lk]--;
            res.retired = 1'b1;
            res.present = slot_present[lk][slot];
            res.owner = slot_present[lk][slot] ? slot_owner[lk][slot] : '0;
            res.last = 1'b0;
            due_results.push_back(res);
            k++;
          end
        end
        if (k == 0) begin
          res = '0;
          res.last = 1'b1;
          due_results.push_back(res);
        end else begin
          res = due_results.pop_back();
          res.last = 1'b1;
          due_results.push_back(res);
        end
      end
      default: begin
        due_results.push_back(res);
      end
    endcase
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    seen_count++;
    if (due_results.size() == 0) begin
      bad_count++;
      if (bad_count <= 10) begin
        $display("result %0d unexpected: status %0d retired %0b owner %0h %s %0b %s %0b",
                 seen_count, got.status, got.retired, got.owner,
                 "present", got.present, "last", got.last);
      end
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status || got.retired !== want.retired ||
          got.owner !== want.owner || got.present !== want.present ||
          got.last !== want.last) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("result %0d mismatch: expected status %0d retired %0b owner %0h %s",
                   seen_count, want.status, want.retired, want.owner,
                   $sformatf("present %0b last %0b", want.present, want.last));
          $display("result %0d mismatch: got      status %0d retired %0b owner %0h %s",
                   seen_count, got.status, got.retired, got.owner,
                   $sformatf("present %0b last %0b", got.present, got.last));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    req_t    rq;
    result_t got;
    if (rst) begin
      for (int i = 0; i < LINK_COUNT; i++) begin
        ring_start[i] = 0;
        ring_used[i] = 0;
      end
      due_results.delete();
      bad_count = 0;
      seen_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser[1:0];
        got.retired = m_axis_tuser[2];
        got.owner = m_axis_tdata[7:0];
        got.present = m_axis_tdata[8];
        got.last = m_axis_tlast;
        check_result(got);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rq.mode = s_axis_tuser;
        rq.link = s_axis_tdata[1:0];
        rq.owner_tag = s_axis_tdata[9:2];
        rq.owner_present = s_axis_tdata[10];
        rq.packet_count = s_axis_tdata[26:11];
        track_request(rq);
      end
    end
    mismatches <= bad_count;
    outstanding <= due_results.size();
  end

endmodule

@@ tb/sv/tx_completion_tracker_top_tb.sv @@
`timescale 1ns / 1ps

module tx_completion_tracker_top_tb;
  import tct_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BLOCKS = 11;
  localparam int BLOCK_ITEMS = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int stall_left = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  always #1 clk = ~clk;

  tx_completion_tracker_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  tx_completion_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_calm || $urandom_range(0, 99) >= 25) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= idle_span();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [LINK_IN_W-1:0] lk,
                              input logic [TAG_W-1:0] tag, input logic pres,
                              input logic [CNT_W-1:0] cnt);
    int gap;
    gap = tx_calm ? 0 : idle_span();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, cnt, pres, tag, lk};
    s_axis_tuser <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_request(input logic [LINK_IN_W-1:0] focus);
    logic [MODE_W-1:0]    mode;
    logic [LINK_IN_W-1:0] lk;
    logic [CNT_W-1:0]     cnt;
    int                   r;
    int                   c;
    r = $urandom_range(0, 99);
    c = $urandom_range(0, 99);
    lk = ($urandom_range(0, 99) < 70) ? focus : LINK_IN_W'($urandom_range(0, 3));
    cnt = CNT_W'($urandom);
    if (r < 45) begin
      mode = MODE_RESERVE;
      if (c < 80) cnt = CNT_W'($urandom_range(1, 6));
      else if (c < 88) cnt = '0;
      else if (c < 93) cnt = '1;
    end else if (r < 82) begin
      mode = MODE_COMPLETE;
      if (c < 75) cnt = CNT_W'($urandom_range(0, 10));
      else if (c < 85) cnt = '1;
    end else if (r < 95) begin
      mode = MODE_RELEASE;
    end else begin
      mode = MODE_UNUSED;
    end
    send_request(mode, lk, TAG_W'($urandom), 1'($urandom), cnt);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(MODE_COMPLETE, 2'd0, 8'h00, 1'b0, 16'd5);
    send_request(MODE_RELEASE, 2'd1, 8'h00, 1'b0, 16'd0);
    send_request(MODE_RESERVE, 2'd0, 8'h11, 1'b1, 16'd0);
    send_request(MODE_UNUSED, 2'd2, 8'h5a, 1'b1, 16'd9);
    send_request(MODE_RESERVE, 2'd0, 8'h00, 1'b1, 16'd3);
    send_request(MODE_RESERVE, 2'd0, 8'hff, 1'b1, 16'd1);
    send_request(MODE_RESERVE, 2'd0, 8'ha5, 1'b0, 16'd2);
    send_request(MODE_RESERVE, 2'd0, 8'h3c, 1'b1, 16'd1);
    send_request(MODE_RESERVE, 2'd0, 8'hc3, 1'b0, 16'd1);
    send_request(MODE_RESERVE, 2'd0, 8'h01, 1'b1, 16'd1);
    send_request(MODE_RESERVE, 2'd0, 8'h80, 1'b1, 16'd1);
    send_request(MODE_RESERVE, 2'd0, 8'h7f, 1'b1, 16'd1);
    send_request(MODE_RESERVE, 2'd0, 8'h42, 1'b1, 16'd4);
    send_request(MODE_COMPLETE, 2'd0, 8'h00, 1'b0, 16'd0);
    send_request(MODE_COMPLETE, 2'd0, 8'h00, 1'b0, 16'd2);
    send_request(MODE_COMPLETE, 2'd0, 8'hff, 1'b1, 16'hffff);
    send_request(MODE_RELEASE, 2'd0, 8'h00, 1'b0, 16'd0);
    send_request(MODE_RESERVE, 2'd3, 8'hff, 1'b1, 16'hffff);
    send_request(MODE_RESERVE, 2'd3, 8'h24, 1'b0, 16'd1);
    send_request(MODE_RELEASE, 2'd3, 8'hff, 1'b1, 16'hffff);
    send_request(MODE_COMPLETE, 2'd3, 8'h00, 1'b0, 16'hfffe);
    send_request(MODE_COMPLETE, 2'd3, 8'h00, 1'b0, 16'd1);
    send_request(MODE_COMPLETE, 2'd2, 8'h00, 1'b0, 16'hffff);
    send_request(MODE_UNUSED, 2'd3, 8'hff, 1'b1, 16'hffff);
    drain_results();

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      tx_calm = (b % 4 == 2);
      rx_calm = (b % 4 == 2);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        random_request(LINK_IN_W'(b % 4));
      end
      if (b == 5) drain_results();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ tx_completion_tracker_top.f @@
rtl/core/tct_pkg.sv
rtl/core/tct_ram.sv
rtl/core/tct_sub.sv
rtl/core/tct_seq.sv
rtl/core/tx_completion_tracker_top.sv
tb/sv/tx_completion_checker.sv
tb/sv/tx_completion_tracker_top_tb.sv
